/* sv/kgmt_pkg.sv */
// ----------------------------------------------------------------------------
// Knob gesture mode toggle package
// Shared widths, command and register codes, reset values and the result word.
// ----------------------------------------------------------------------------
package kgmt_pkg;

    localparam int SECTOR_W = 7;
    localparam int LEVEL_W  = 16;
    localparam int WINDOW_W = 10;
    localparam int STEP_W   = 3;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_POLL  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_FAULT = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ARM_A   = 3'd0,
        REG_ARM_B   = 3'd1,
        REG_ARM_C   = 3'd2,
        REG_SPECIAL = 3'd3,
        REG_LOW     = 3'd4,
        REG_HIGH    = 3'd5,
        REG_WINDOW  = 3'd6,
        REG_UNUSED  = 3'd7
    } cfg_reg_t;

    typedef enum logic [STEP_W-1:0] {
        STEP_ARM   = 3'd0,
        STEP_LOW1  = 3'd1,
        STEP_HIGH1 = 3'd2,
        STEP_LOW2  = 3'd3,
        STEP_HIGH2 = 3'd4,
        STEP_LOW3  = 3'd5,
        STEP_HIGH3 = 3'd6,
        STEP_BAD   = 3'd7
    } step_t;

    localparam logic [SECTOR_W-1:0] ARM_A_RST   = 7'd0;
    localparam logic [SECTOR_W-1:0] ARM_B_RST   = 7'd1;
    localparam logic [SECTOR_W-1:0] ARM_C_RST   = 7'd2;
    localparam logic [SECTOR_W-1:0] SPECIAL_RST = 7'd3;
    localparam logic [LEVEL_W-1:0]  LOW_RST     = 16'd1637;
    localparam logic [LEVEL_W-1:0]  HIGH_RST    = 16'd14731;
    localparam logic [WINDOW_W-1:0] WINDOW_RST  = 10'(1 * 8 * 60);
    localparam logic [SECTOR_W:0]   NO_SECTOR   = 8'hFF;

    typedef struct packed {
        logic                mode_on;
        logic                special_flag;
        logic                enable_pulse;
        logic                disable_pulse;
        logic [STEP_W-1:0]   gesture_step;
        logic [WINDOW_W-1:0] window_left;
    } result_t;

endpackage

/* sv/knob_gesture_mode_toggle_top.sv */
// ----------------------------------------------------------------------------
// Knob gesture mode toggle
// Detects the hidden-mode gesture on a selector knob and reports the mode.
// ----------------------------------------------------------------------------
// Each input word carries a command (poll, tick or sensor fault), the knob
// sector and the trim level. A word is taken at a clock edge where in_valid
// is high and in_stall is low, and exactly one result word follows on the
// output channel, taken where out_valid is high and out_stall is low.
// The result of a word is registered at the edge that takes it, into the output
// register or, while the output is stalled, the skid register. A new word can be
// taken every cycle while in_stall is low; the block state is updated in the same
// edge, so back-to-back words see each other's effects.
// An output register and a skid register follow the logic. When the receiver
// stalls, the result holds and one more word is taken into the skid register;
// in_stall then rises until the output drains.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect at the
// next edge; the user must make them while the block is idle; the block does not enforce it.
// Reset restores the register defaults, forgets the last sector, closes the
// window, clears both flags and empties the output.
// ----------------------------------------------------------------------------
module knob_gesture_mode_toggle_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [kgmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kgmt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [kgmt_pkg::CMD_W-1:0]      command,
    input  logic [kgmt_pkg::SECTOR_W-1:0]   sector,
    input  logic [kgmt_pkg::LEVEL_W-1:0]    trim_level,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            mode_on,
    output logic                            special_flag,
    output logic                            enable_pulse,
    output logic                            disable_pulse,
    output logic [kgmt_pkg::STEP_W-1:0]     gesture_step,
    output logic [kgmt_pkg::WINDOW_W-1:0]   window_left
);

    logic [kgmt_pkg::SECTOR_W-1:0] arm_a_reg;
    logic [kgmt_pkg::SECTOR_W-1:0] arm_b_reg;
    logic [kgmt_pkg::SECTOR_W-1:0] arm_c_reg;
    logic [kgmt_pkg::SECTOR_W-1:0] special_sector_reg;
    logic [kgmt_pkg::LEVEL_W-1:0]  low_level_reg;
    logic [kgmt_pkg::LEVEL_W-1:0]  high_level_reg;
    logic [kgmt_pkg::WINDOW_W-1:0] window_ticks_reg;

    logic [kgmt_pkg::SECTOR_W:0]   last_sector_reg, last_sector_next;
    logic [kgmt_pkg::WINDOW_W-1:0] window_reg, window_next;
    logic [kgmt_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          special_reg, special_next;
    logic                          mode_reg, mode_next;
    logic                          en_next, dis_next;

    kgmt_pkg::result_t out_reg, skid_reg, result_next;
    logic              out_valid_reg, skid_valid_reg;

    logic in_fire, out_fire, is_arming, is_low, is_high;
    logic [kgmt_pkg::WINDOW_W-1:0] window_dec;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_a_reg          <= kgmt_pkg::ARM_A_RST;
            arm_b_reg          <= kgmt_pkg::ARM_B_RST;
            arm_c_reg          <= kgmt_pkg::ARM_C_RST;
            special_sector_reg <= kgmt_pkg::SPECIAL_RST;
            low_level_reg      <= kgmt_pkg::LOW_RST;
            high_level_reg     <= kgmt_pkg::HIGH_RST;
            window_ticks_reg   <= kgmt_pkg::WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (kgmt_pkg::cfg_reg_t'(cfg_index))
                kgmt_pkg::REG_ARM_A:   arm_a_reg <= cfg_data[kgmt_pkg::SECTOR_W-1:0];
                kgmt_pkg::REG_ARM_B:   arm_b_reg <= cfg_data[kgmt_pkg::SECTOR_W-1:0];
                kgmt_pkg::REG_ARM_C:   arm_c_reg <= cfg_data[kgmt_pkg::SECTOR_W-1:0];
                kgmt_pkg::REG_SPECIAL:
                    special_sector_reg <= cfg_data[kgmt_pkg::SECTOR_W-1:0];
                kgmt_pkg::REG_LOW:     low_level_reg <= cfg_data[kgmt_pkg::LEVEL_W-1:0];
                kgmt_pkg::REG_HIGH:    high_level_reg <= cfg_data[kgmt_pkg::LEVEL_W-1:0];
                kgmt_pkg::REG_WINDOW:
                    window_ticks_reg <= cfg_data[kgmt_pkg::WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    assign is_arming  = (sector == arm_a_reg) || (sector == arm_b_reg)
                        || (sector == arm_c_reg);
    assign is_low     = trim_level < low_level_reg;
    assign is_high    = trim_level > high_level_reg;
    assign window_dec = window_reg - 1'b1;

    always_comb
    begin
        last_sector_next = last_sector_reg;
        window_next      = window_reg;
        step_next        = step_reg;
        special_next     = special_reg;
        mode_next        = mode_reg;
        en_next          = 1'b0;
        dis_next         = 1'b0;
        unique case (kgmt_pkg::cmd_t'(command))
            kgmt_pkg::CMD_POLL:
            begin
                if (last_sector_reg != {1'b0, sector})
                begin
                    last_sector_next = {1'b0, sector};
                    if (is_arming)
                        window_next = window_ticks_reg;
                    if (sector == special_sector_reg)
                    begin
                        if (!mode_reg)
                            special_next = 1'b1;
                    end
                    else
                        special_next = 1'b0;
                end
            end
            kgmt_pkg::CMD_TICK:
            begin
                if (window_reg != '0)
                begin
                    window_next = window_dec;
                    unique case (kgmt_pkg::step_t'(step_reg)) inside
                        kgmt_pkg::STEP_ARM:
                            if (is_arming)
                                step_next = kgmt_pkg::STEP_LOW1;
                        kgmt_pkg::STEP_LOW1, kgmt_pkg::STEP_LOW2, kgmt_pkg::STEP_LOW3:
                            if (is_low)
                                step_next = step_reg + 1'b1;
                        kgmt_pkg::STEP_HIGH1, kgmt_pkg::STEP_HIGH2:
                            if (is_high)
                                step_next = step_reg + 1'b1;
                        kgmt_pkg::STEP_HIGH3:
                            if (is_high)
                            begin
                                step_next   = kgmt_pkg::STEP_ARM;
                                window_next = '0;
                                mode_next   = !mode_reg;
                                en_next     = !mode_reg;
                                dis_next    = mode_reg;
                            end
                        default: step_next = kgmt_pkg::STEP_ARM;
                    endcase
                    if (window_next == '0)
                        step_next = kgmt_pkg::STEP_ARM;
                end
            end
            kgmt_pkg::CMD_FAULT:
            begin
                special_next = 1'b0;
                mode_next    = 1'b0;
                dis_next     = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        result_next.mode_on       = mode_next;
        result_next.special_flag  = special_next;
        result_next.enable_pulse  = en_next;
        result_next.disable_pulse = dis_next;
        result_next.gesture_step  = step_next;
        result_next.window_left   = window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sector_reg <= kgmt_pkg::NO_SECTOR;
            window_reg      <= '0;
            step_reg        <= kgmt_pkg::STEP_ARM;
            special_reg     <= 1'b0;
            mode_reg        <= 1'b0;
        end
        else if (in_fire)
        begin
            last_sector_reg <= last_sector_next;
            window_reg      <= window_next;
            step_reg        <= step_next;
            special_reg     <= special_next;
            mode_reg        <= mode_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
                out_reg <= result_next;
            else
                skid_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mode_on       = out_reg.mode_on;
    assign special_flag  = out_reg.special_flag;
    assign enable_pulse  = out_reg.enable_pulse;
    assign disable_pulse = out_reg.disable_pulse;
    assign gesture_step  = out_reg.gesture_step;
    assign window_left   = out_reg.window_left;

endmodule

/* sv/kgmt_checker.sv */
// ----------------------------------------------------------------------------
// Knob gesture mode toggle checker
// Port-level assertions on the result words, bound to the top level.
// ----------------------------------------------------------------------------
module kgmt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          mode_on,
    input logic                          special_flag,
    input logic                          enable_pulse,
    input logic                          disable_pulse,
    input logic [kgmt_pkg::STEP_W-1:0]   gesture_step,
    input logic [kgmt_pkg::WINDOW_W-1:0] window_left
);

    // A word never switches the mode on and off at once.
    a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(enable_pulse && disable_pulse))
        else $error("enable and disable pulses in the same word");

    a_enable_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && enable_pulse |-> mode_on)
        else $error("enable pulse without the mode on");

    a_disable_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && disable_pulse |-> !mode_on)
        else $error("disable pulse with the mode still on");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({mode_on, special_flag, enable_pulse,
        disable_pulse, gesture_step, window_left}))
        else $error("unknown bits in a result word");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(gesture_step)
        && $stable(window_left) && $stable(mode_on))
        else $error("stalled result word changed");

endmodule

bind knob_gesture_mode_toggle_top kgmt_checker u_kgmt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mode_on      (mode_on),
    .special_flag (special_flag),
    .enable_pulse (enable_pulse),
    .disable_pulse(disable_pulse),
    .gesture_step (gesture_step),
    .window_left  (window_left)
);

/* tb/gesture_tracker_pkg.sv */
// ----------------------------------------------------------------------------
// Gesture tracker scoreboard
// Mirrors the knob gesture state and registers, predicts one status word per
// accepted input word and checks each output word against the oldest one.
// ----------------------------------------------------------------------------
package gesture_tracker_pkg;

    import kgmt_pkg::*;

    class gesture_tracker;

        logic [SECTOR_W-1:0] arm_a;
        logic [SECTOR_W-1:0] arm_b;
        logic [SECTOR_W-1:0] arm_c;
        logic [SECTOR_W-1:0] special_sec;
        logic [LEVEL_W-1:0]  low_level;
        logic [LEVEL_W-1:0]  high_level;
        logic [WINDOW_W-1:0] window_ticks;

        logic [SECTOR_W:0]   last_sector;
        logic [WINDOW_W-1:0] window_count;
        step_t               step;
        bit                  special_bit;
        bit                  mode_bit;

        result_t             expected_status[$];
        int                  errors;

        function new();
            arm_a        = ARM_A_RST;
            arm_b        = ARM_B_RST;
            arm_c        = ARM_C_RST;
            special_sec  = SPECIAL_RST;
            low_level    = LOW_RST;
            high_level   = HIGH_RST;
            window_ticks = WINDOW_RST;
            last_sector  = NO_SECTOR;
            window_count = '0;
            step         = STEP_ARM;
            special_bit  = 1'b0;
            mode_bit     = 1'b0;
            errors       = 0;
        endfunction

        function bit is_arming(logic [SECTOR_W-1:0] s);
            return s == arm_a || s == arm_b || s == arm_c;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_ARM_A:   arm_a        = d[SECTOR_W-1:0];
                REG_ARM_B:   arm_b        = d[SECTOR_W-1:0];
                REG_ARM_C:   arm_c        = d[SECTOR_W-1:0];
                REG_SPECIAL: special_sec  = d[SECTOR_W-1:0];
                REG_LOW:     low_level    = d[LEVEL_W-1:0];
                REG_HIGH:    high_level   = d[LEVEL_W-1:0];
                REG_WINDOW:  window_ticks = d[WINDOW_W-1:0];
                default:     ;
            endcase
        endfunction

        function void note_word(cmd_t c, logic [SECTOR_W-1:0] s, logic [LEVEL_W-1:0] t);
            result_t r;
            bit      en;
            bit      dis;
            bit      lo;
            bit      hi;
            en  = 1'b0;
            dis = 1'b0;
            case (c)
                CMD_POLL:
                begin
                    if (last_sector != {1'b0, s})
                    begin
                        last_sector = {1'b0, s};
                        if (is_arming(s))
                            window_count = window_ticks;
                        if (s == special_sec)
                        begin
                            if (!special_bit && !mode_bit)
                                special_bit = 1'b1;
                        end
                        else
                            special_bit = 1'b0;
                    end
                end
                CMD_TICK:
                begin
                    if (window_count != 0)
                    begin
                        lo = t < low_level;
                        hi = t > high_level;
                        window_count = window_count - 1'b1;
                        case (step) inside
                            STEP_ARM:
                                if (is_arming(s))
                                    step = STEP_LOW1;
                            STEP_LOW1, STEP_LOW2, STEP_LOW3:
                                if (lo)
                                    step = step_t'(step + 1);
                            STEP_HIGH1, STEP_HIGH2:
                                if (hi)
                                    step = step_t'(step + 1);
                            STEP_HIGH3:
                                if (hi)
                                begin
                                    step         = STEP_ARM;
                                    window_count = '0;
                                    mode_bit     = !mode_bit;
                                    en           = mode_bit;
                                    dis          = !mode_bit;
                                end
                            default:
                                step = STEP_ARM;
                        endcase
                        if (window_count == 0)
                            step = STEP_ARM;
                    end
                end
                CMD_FAULT:
                begin
                    special_bit = 1'b0;
                    mode_bit    = 1'b0;
                    dis         = 1'b1;
                end
                default: ;
            endcase
            r.mode_on       = mode_bit;
            r.special_flag  = special_bit;
            r.enable_pulse  = en;
            r.disable_pulse = dis;
            r.gesture_step  = step;
            r.window_left   = window_count;
            expected_status.push_back(r);
        endfunction

        task report(string what, int got_v, int want_v);
            if (errors < 200)
                $display("mismatch on %s: got %0d, expected %0d", what, got_v, want_v);
            errors++;
        endtask

        task check_status(result_t got);
            result_t want;
            if (expected_status.size() == 0)
            begin
                report("word with none pending", int'(got.window_left), -1);
                return;
            end
            want = expected_status.pop_front();
            if (got.mode_on !== want.mode_on)
                report("mode_on", int'(got.mode_on), int'(want.mode_on));
            if (got.special_flag !== want.special_flag)
                report("special_flag", int'(got.special_flag), int'(want.special_flag));
            if (got.enable_pulse !== want.enable_pulse)
                report("enable_pulse", int'(got.enable_pulse), int'(want.enable_pulse));
            if (got.disable_pulse !== want.disable_pulse)
                report("disable_pulse", int'(got.disable_pulse), int'(want.disable_pulse));
            if (got.gesture_step !== want.gesture_step)
                report("gesture_step", int'(got.gesture_step), int'(want.gesture_step));
            if (got.window_left !== want.window_left)
                report("window_left", int'(got.window_left), int'(want.window_left));
        endtask

    endclass

endpackage

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Knob gesture mode toggle testbench
// Drives poll, tick and fault words through the block under several register
// settings, with random gaps and stalls, and checks every status word.
// ----------------------------------------------------------------------------
module tb_top;

    import kgmt_pkg::*;
    import gesture_tracker_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [CMD_W-1:0]      command;
    logic [SECTOR_W-1:0]   sector;
    logic [LEVEL_W-1:0]    trim_level;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  mode_on;
    logic                  special_flag;
    logic                  enable_pulse;
    logic                  disable_pulse;
    logic [STEP_W-1:0]     gesture_step;
    logic [WINDOW_W-1:0]   window_left;

    gesture_tracker tracker = new();
    bit             calm = 1'b0;
    int             words_sent = 0;
    int             cycles = 0;

    knob_gesture_mode_toggle_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .sector        (sector),
        .trim_level    (trim_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mode_on       (mode_on),
        .special_flag  (special_flag),
        .enable_pulse  (enable_pulse),
        .disable_pulse (disable_pulse),
        .gesture_step  (gesture_step),
        .window_left   (window_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 17);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            tracker.check_status({mode_on, special_flag, enable_pulse, disable_pulse,
                                  gesture_step, window_left});

    task automatic send_word(cmd_t c, logic [SECTOR_W-1:0] s, logic [LEVEL_W-1:0] t);
        while (!calm && $urandom_range(99) < 17)
        begin
            in_valid   = 1'b0;
            command    = CMD_W'($urandom);
            sector     = SECTOR_W'($urandom);
            trim_level = LEVEL_W'($urandom);
            @(negedge clk);
        end
        in_valid   = 1'b1;
        command    = c;
        sector     = s;
        trim_level = t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_word(c, s, t);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        tracker.write_reg(idx, d);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_all(int a, int b, int c, int sp, int lo, int hi, int win);
        write_reg(REG_ARM_A, {9'h1FF, 7'(a)});
        write_reg(REG_ARM_B, {9'($urandom_range(511)), 7'(b)});
        write_reg(REG_ARM_C, {9'h000, 7'(c)});
        write_reg(REG_SPECIAL, {9'($urandom_range(511)), 7'(sp)});
        write_reg(REG_LOW, 16'(lo));
        write_reg(REG_HIGH, 16'(hi));
        write_reg(REG_WINDOW, 16'(win));
    endtask

    function automatic logic [LEVEL_W-1:0] low_trim();
        if (tracker.low_level == 0)
            return '0;
        return LEVEL_W'($urandom_range(int'(tracker.low_level) - 1, 0));
    endfunction

    function automatic logic [LEVEL_W-1:0] high_trim();
        if (tracker.high_level == 16'hFFFF)
            return 16'hFFFF;
        return LEVEL_W'($urandom_range(65535, int'(tracker.high_level) + 1));
    endfunction

    task automatic send_noise();
        logic [SECTOR_W-1:0] s;
        s = ($urandom_range(9) == 0) ? tracker.special_sec : SECTOR_W'($urandom);
        send_word(cmd_t'($urandom_range(3)), s, LEVEL_W'($urandom));
    endtask

    task automatic send_gesture();
        logic [SECTOR_W-1:0] arm;
        logic [LEVEL_W-1:0]  t;
        case ($urandom_range(2))
            0:       arm = tracker.arm_a;
            1:       arm = tracker.arm_b;
            default: arm = tracker.arm_c;
        endcase
        if ($urandom_range(1))
            send_word(CMD_POLL, SECTOR_W'($urandom), LEVEL_W'($urandom));
        send_word(CMD_POLL, arm, LEVEL_W'($urandom));
        send_word(CMD_TICK, arm, LEVEL_W'($urandom));
        for (int k = 1; k <= 6; k++)
        begin
            if ($urandom_range(99) < 10)
                send_noise();
            if ($urandom_range(99) < 5)
                t = LEVEL_W'($urandom);
            else
                t = (k % 2) ? low_trim() : high_trim();
            send_word(CMD_TICK, SECTOR_W'($urandom), t);
        end
    endtask

    task automatic random_traffic(int n);
        int stop_at;
        stop_at = words_sent + n;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(99) < 70)
                send_gesture();
            else
                send_noise();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        command    = CMD_NONE;
        sector     = '0;
        trim_level = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_word(CMD_TICK, 7'd0, 16'd0);
        send_word(CMD_NONE, 7'd127, 16'hFFFF);
        send_word(CMD_POLL, 7'd3, 16'd0);
        send_word(CMD_POLL, 7'd3, 16'hFFFF);
        send_word(CMD_POLL, 7'd127, 16'd0);
        send_word(CMD_POLL, 7'd0, 16'd0);
        send_word(CMD_TICK, 7'd0, 16'hFFFF);
        send_word(CMD_TICK, 7'd127, 16'd0);
        send_word(CMD_TICK, 7'd5, 16'hFFFF);
        send_word(CMD_TICK, 7'd5, 16'd1636);
        send_word(CMD_TICK, 7'd5, 16'd14732);
        send_word(CMD_TICK, 7'd5, 16'd1637);
        send_word(CMD_TICK, 7'd5, 16'd0);
        send_word(CMD_TICK, 7'd5, 16'd14731);
        send_word(CMD_TICK, 7'd5, 16'hFFFF);
        send_word(CMD_POLL, 7'd3, 16'd0);
        send_word(CMD_POLL, 7'd1, 16'd0);
        send_word(CMD_FAULT, 7'd1, 16'd0);
        send_word(CMD_FAULT, 7'd127, 16'hFFFF);
        send_word(CMD_TICK, 7'd2, 16'd0);
        random_traffic(150);

        wait_idle();
        write_all($urandom, $urandom, $urandom, $urandom, $urandom_range(20000, 1000),
                  $urandom_range(60000, 30000), $urandom_range(20, 6));
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        random_traffic(150);

        wait_idle();
        write_all(127, 0, 127, 127, 65535, 0, 65535);
        random_traffic(80);

        wait_idle();
        write_all(5, 6, 7, 8, 0, 65535, 0);
        send_word(CMD_POLL, 7'd5, 16'd0);
        send_word(CMD_TICK, 7'd5, 16'd0);
        random_traffic(40);

        wait_idle();
        write_all($urandom, $urandom, $urandom, $urandom, $urandom_range(30000, 1),
                  $urandom_range(65534, 30000), 1);
        random_traffic(60);

        wait_idle();
        write_all($urandom, $urandom, $urandom, $urandom, $urandom_range(30000, 1),
                  $urandom_range(65534, 30000), $urandom_range(60, 20));
        calm = 1'b1;
        random_traffic(120);
        calm = 1'b0;
        random_traffic(100);

        wait_idle();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
sv/kgmt_pkg.sv
sv/knob_gesture_mode_toggle_top.sv
sv/kgmt_checker.sv
tb/gesture_tracker_pkg.sv
tb/tb_top.sv
